### rtl/core/rwl_pkg.sv
package rwl_pkg;

	// table geometry
	localparam int THREADS = 16;
	localparam int PER_THREAD_BITS = 8;
	localparam int TID_W = $clog2(THREADS);

	// field widths
	localparam int OP_W = 4;
	localparam int THREAD_ID_W = 4;
	localparam int STATUS_W = 3;
	localparam int WAKE_W = 2;
	localparam int TOTAL_W = 12;
	localparam int NEST_W = 8;
	localparam int WAIT_W = 5;

	// counter limits
	localparam logic [PER_THREAD_BITS-1:0] PT_MAX = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
	localparam logic [NEST_W-1:0] NEST_MAX = '1;
	localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

	// operation codes
	localparam logic [OP_W-1:0] OP_READ_REQ = 4'd0;
	localparam logic [OP_W-1:0] OP_WRITE_REQ = 4'd1;
	localparam logic [OP_W-1:0] OP_LOCKOUT = 4'd2;
	localparam logic [OP_W-1:0] OP_REALLOW = 4'd3;
	localparam logic [OP_W-1:0] OP_UNLOCK_READ = 4'd4;
	localparam logic [OP_W-1:0] OP_UNLOCK_WRITE = 4'd5;
	localparam logic [OP_W-1:0] OP_RETRY_READ = 4'd6;
	localparam logic [OP_W-1:0] OP_RETRY_WRITE = 4'd7;
	localparam logic [OP_W-1:0] OP_RETRY_LOCKOUT = 4'd8;
	localparam logic [OP_W-1:0] OP_ABANDON_READ = 4'd9;
	localparam logic [OP_W-1:0] OP_ABANDON_WRITE = 4'd10;
	localparam logic [OP_W-1:0] OP_ABANDON_LOCKOUT = 4'd11;

	// status codes
	localparam logic [STATUS_W-1:0] ST_GRANT = 3'd0;
	localparam logic [STATUS_W-1:0] ST_WAIT = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DEADLOCK = 3'd2;
	localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ABANDON = 3'd4;
	localparam logic [STATUS_W-1:0] ST_MISUSE = 3'd5;

	// wake classes
	localparam logic [WAKE_W-1:0] WAKE_NONE = 2'd0;
	localparam logic [WAKE_W-1:0] WAKE_READERS = 2'd1;
	localparam logic [WAKE_W-1:0] WAKE_WRITERS = 2'd2;
	localparam logic [WAKE_W-1:0] WAKE_UPGRADERS = 2'd3;

	// write port of the per-thread count table
	typedef struct packed {
		logic en;
		logic [TID_W-1:0] addr;
		logic [PER_THREAD_BITS-1:0] data;
	} cnt_wr_t;

	// one result item
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [WAKE_W-1:0] wake_class;
		logic [TOTAL_W-1:0] reader_total;
		logic [NEST_W-1:0] nest_level;
	} rwl_result_t;

endpackage

### rtl/core/rwl_req_if.sv
interface rwl_req_if;
	import rwl_pkg::*;

	logic valid;
	logic ready;
	logic [OP_W-1:0] op;
	logic [THREAD_ID_W-1:0] thread_id;
	logic keep_readers;

	modport source (output valid, output op, output thread_id, output keep_readers,
		input ready);
	modport sink (input valid, input op, input thread_id, input keep_readers,
		output ready);
endinterface

### rtl/core/rwl_rsp_if.sv
interface rwl_rsp_if;
	import rwl_pkg::*;

	logic valid;
	logic ready;
	logic [STATUS_W-1:0] status;
	logic [WAKE_W-1:0] wake_class;
	logic [TOTAL_W-1:0] reader_total_out;
	logic [NEST_W-1:0] nest_level_out;

	modport source (output valid, output status, output wake_class,
		output reader_total_out, output nest_level_out, input ready);
	modport sink (input valid, input status, input wake_class,
		input reader_total_out, input nest_level_out, output ready);
endinterface

### rtl/core/rwl_count_ram.sv
module rwl_count_ram (
	input logic clk,
	input logic arst_n,
	input logic rd_en,
	input logic [rwl_pkg::TID_W-1:0] rd_addr,
	input rwl_pkg::cnt_wr_t wr,
	output logic [rwl_pkg::PER_THREAD_BITS-1:0] rd_data
);
	import rwl_pkg::*;

	logic [PER_THREAD_BITS-1:0] mem [THREADS];
	logic [THREADS-1:0] valid_q;
	logic [PER_THREAD_BITS-1:0] rd_data_q;

	// table storage
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// entry valid bits, an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	// registered read, forwarded from a write to the same entry at the same edge
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr.en && wr.addr == rd_addr) begin
				rd_data_q <= wr.data;
			end else if (valid_q[rd_addr]) begin
				rd_data_q <= mem[rd_addr];
			end else begin
				rd_data_q <= '0;
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/core/rwl_engine.sv
module rwl_engine (
	input logic clk,
	input logic arst_n,
	input logic fire,
	input logic [rwl_pkg::OP_W-1:0] op,
	input logic [rwl_pkg::THREAD_ID_W-1:0] thread_id,
	input logic keep_readers,
	input logic [rwl_pkg::PER_THREAD_BITS-1:0] pt_count,
	output rwl_pkg::cnt_wr_t wr,
	output rwl_pkg::rwl_result_t result
);
	import rwl_pkg::*;

	logic writer_valid_q;
	logic [THREAD_ID_W-1:0] writer_owner_q;
	logic [NEST_W-1:0] nest_level_q;
	logic readers_admitted_q;
	logic [TOTAL_W-1:0] reader_total_q;
	logic [WAIT_W-1:0] wait_read_q;
	logic [WAIT_W-1:0] wait_write_q;
	logic [WAIT_W-1:0] wait_upgrade_q;

	logic writer_valid_n;
	logic [THREAD_ID_W-1:0] writer_owner_n;
	logic [NEST_W-1:0] nest_level_n;
	logic readers_admitted_n;
	logic [TOTAL_W-1:0] reader_total_n;
	logic [WAIT_W-1:0] wait_read_n;
	logic [WAIT_W-1:0] wait_write_n;
	logic [WAIT_W-1:0] wait_upgrade_n;
	logic [PER_THREAD_BITS-1:0] pt_n;
	logic pt_we;
	logic [STATUS_W-1:0] status;
	logic [WAKE_W-1:0] wake;
	logic [WAKE_W-1:0] wake_pick;
	logic self_writer;
	logic known_tid;
	logic can_admit;

	// wake priority: upgraders, writers, readers
	always_comb begin
		if (wait_upgrade_q != '0) begin
			wake_pick = WAKE_UPGRADERS;
		end else if (wait_write_q != '0) begin
			wake_pick = WAKE_WRITERS;
		end else if (wait_read_q != '0) begin
			wake_pick = WAKE_READERS;
		end else begin
			wake_pick = WAKE_NONE;
		end
	end

	assign known_tid = int'(thread_id) < THREADS;
	assign self_writer = writer_valid_q && (writer_owner_q == thread_id);
	assign can_admit = (reader_total_q != TOTAL_MAX) && (pt_count != PT_MAX);

	// operation decode and next state
	always_comb begin
		status = ST_MISUSE;
		wake = WAKE_NONE;
		writer_valid_n = writer_valid_q;
		writer_owner_n = writer_owner_q;
		nest_level_n = nest_level_q;
		readers_admitted_n = readers_admitted_q;
		reader_total_n = reader_total_q;
		wait_read_n = wait_read_q;
		wait_write_n = wait_write_q;
		wait_upgrade_n = wait_upgrade_q;
		pt_n = pt_count;
		pt_we = 1'b0;
		if (known_tid) begin
			case (op)
				OP_READ_REQ: begin
					if (self_writer) begin
						if (nest_level_q != NEST_MAX) begin
							nest_level_n = nest_level_q + 1'b1;
							status = ST_GRANT;
						end
					end else if (readers_admitted_q) begin
						if (can_admit) begin
							reader_total_n = reader_total_q + 1'b1;
							pt_n = pt_count + 1'b1;
							pt_we = 1'b1;
							status = ST_GRANT;
						end
					end else if (wait_read_q != WAIT_MAX) begin
						wait_read_n = wait_read_q + 1'b1;
						status = ST_WAIT;
					end
				end
				OP_WRITE_REQ: begin
					if (self_writer) begin
						if (nest_level_q != NEST_MAX) begin
							nest_level_n = nest_level_q + 1'b1;
							status = ST_GRANT;
						end
					end else if (!writer_valid_q && reader_total_q == '0) begin
						writer_valid_n = 1'b1;
						writer_owner_n = thread_id;
						nest_level_n = NEST_W'(1);
						readers_admitted_n = keep_readers;
						status = ST_GRANT;
					end else if (pt_count != '0) begin
						status = ST_DEADLOCK;
					end else if (wait_write_q != WAIT_MAX) begin
						wait_write_n = wait_write_q + 1'b1;
						status = ST_WAIT;
					end
				end
				OP_LOCKOUT: begin
					if (reader_total_q == '0) begin
						readers_admitted_n = 1'b0;
						status = ST_GRANT;
					end else if (wait_upgrade_q != WAIT_MAX) begin
						wait_upgrade_n = wait_upgrade_q + 1'b1;
						status = ST_WAIT;
					end
				end
				OP_REALLOW: begin
					readers_admitted_n = 1'b1;
					status = ST_GRANT;
				end
				OP_UNLOCK_READ: begin
					if (self_writer && nest_level_q > NEST_W'(1)) begin
						nest_level_n = nest_level_q - 1'b1;
						status = ST_RELEASED;
					end else if (reader_total_q != '0 && pt_count != '0) begin
						reader_total_n = reader_total_q - 1'b1;
						pt_n = pt_count - 1'b1;
						pt_we = 1'b1;
						status = ST_RELEASED;
						if (reader_total_q == TOTAL_W'(1)) begin
							wake = wake_pick;
						end
					end
				end
				OP_UNLOCK_WRITE: begin
					if (self_writer && nest_level_q > NEST_W'(1)) begin
						nest_level_n = nest_level_q - 1'b1;
						status = ST_RELEASED;
					end else begin
						writer_valid_n = 1'b0;
						writer_owner_n = '0;
						nest_level_n = '0;
						readers_admitted_n = 1'b1;
						status = ST_RELEASED;
						wake = wake_pick;
					end
				end
				OP_RETRY_READ: begin
					if (wait_read_q != '0) begin
						if (!readers_admitted_q) begin
							status = ST_WAIT;
						end else if (can_admit) begin
							reader_total_n = reader_total_q + 1'b1;
							pt_n = pt_count + 1'b1;
							pt_we = 1'b1;
							wait_read_n = wait_read_q - 1'b1;
							status = ST_GRANT;
						end
					end
				end
				OP_RETRY_WRITE: begin
					if (wait_write_q != '0) begin
						if (!writer_valid_q && reader_total_q == '0) begin
							wait_write_n = wait_write_q - 1'b1;
							writer_valid_n = 1'b1;
							writer_owner_n = thread_id;
							nest_level_n = NEST_W'(1);
							readers_admitted_n = keep_readers;
							status = ST_GRANT;
						end else begin
							status = ST_WAIT;
						end
					end
				end
				OP_RETRY_LOCKOUT: begin
					if (wait_upgrade_q != '0) begin
						if (reader_total_q == '0) begin
							wait_upgrade_n = wait_upgrade_q - 1'b1;
							readers_admitted_n = 1'b0;
							status = ST_GRANT;
						end else begin
							status = ST_WAIT;
						end
					end
				end
				OP_ABANDON_READ: begin
					if (wait_read_q != '0) begin
						wait_read_n = wait_read_q - 1'b1;
						status = ST_ABANDON;
					end
				end
				OP_ABANDON_WRITE: begin
					if (wait_write_q != '0) begin
						wait_write_n = wait_write_q - 1'b1;
						status = ST_ABANDON;
					end
				end
				OP_ABANDON_LOCKOUT: begin
					if (wait_upgrade_q != '0) begin
						wait_upgrade_n = wait_upgrade_q - 1'b1;
						status = ST_ABANDON;
					end
				end
				default: begin
					status = ST_MISUSE;
				end
			endcase
		end
	end

	// lock state registers, committed when the operation transfers out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			writer_valid_q <= 1'b0;
			writer_owner_q <= '0;
			nest_level_q <= '0;
			readers_admitted_q <= 1'b1;
			reader_total_q <= '0;
			wait_read_q <= '0;
			wait_write_q <= '0;
			wait_upgrade_q <= '0;
		end else if (fire) begin
			writer_valid_q <= writer_valid_n;
			writer_owner_q <= writer_owner_n;
			nest_level_q <= nest_level_n;
			readers_admitted_q <= readers_admitted_n;
			reader_total_q <= reader_total_n;
			wait_read_q <= wait_read_n;
			wait_write_q <= wait_write_n;
			wait_upgrade_q <= wait_upgrade_n;
		end
	end

	// table write-back and result
	always_comb begin
		wr.en = fire && pt_we;
		wr.addr = TID_W'(thread_id);
		wr.data = pt_n;
		result.status = status;
		result.wake_class = wake;
		result.reader_total = reader_total_n;
		result.nest_level = nest_level_n;
	end

	// a writer always has a nonzero depth, no writer means depth zero
	assert property (@(posedge clk) disable iff (!arst_n)
		writer_valid_q == (nest_level_q != '0))
		else $error("writer flag and nest depth disagree");

	// misuse leaves the lock state untouched
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && status == ST_MISUSE |=> $stable(reader_total_q) && $stable(nest_level_q)
			&& $stable(writer_valid_q) && $stable(wait_read_q)
			&& $stable(wait_write_q) && $stable(wait_upgrade_q))
		else $error("misuse changed lock state");

	// a wake only comes with a release
	assert property (@(posedge clk) disable iff (!arst_n)
		wake != WAKE_NONE |-> status == ST_RELEASED)
		else $error("wake without release");

	// the count table is written only on reader admits and releases
	assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (status == ST_GRANT || status == ST_RELEASED)
			&& reader_total_n != reader_total_q)
		else $error("count table write without reader change");

endmodule

### rtl/core/reader_writer_lock_arbiter_core.sv
// path: a request is registered into stage one and the count table read, then the result register
// throughput: one operation per cycle; the per-thread count table is read and written once a cycle
// with write-back forwarding, so only a low rsp.ready stalls back-to-back operations of one thread
// reset: arst_n clears the lock state, the table valid bits and the pipeline; the table needs
// no clearing pass, so requests are taken as soon as reset is released
module reader_writer_lock_arbiter_core (
	input logic clk,
	input logic arst_n,
	rwl_req_if.sink req,
	rwl_rsp_if.source rsp
);
	import rwl_pkg::*;

	logic valid_s1;
	logic [OP_W-1:0] op_s1;
	logic [THREAD_ID_W-1:0] tid_s1;
	logic keep_s1;
	logic out_valid_q;
	rwl_result_t out_q;
	logic fire;
	logic accept;
	logic [PER_THREAD_BITS-1:0] pt_count;
	cnt_wr_t cnt_wr;
	rwl_result_t result;

	// stage one moves on when the result register is free or being drained
	assign fire = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || fire;
	assign accept = req.valid && req.ready;

	// per-thread read counts
	rwl_count_ram u_count_ram (
		.clk (clk),
		.arst_n (arst_n),
		.rd_en (accept),
		.rd_addr (TID_W'(req.thread_id)),
		.wr (cnt_wr),
		.rd_data (pt_count)
	);

	// lock state and decision logic
	rwl_engine u_engine (
		.clk (clk),
		.arst_n (arst_n),
		.fire (fire),
		.op (op_s1),
		.thread_id (tid_s1),
		.keep_readers (keep_s1),
		.pt_count (pt_count),
		.wr (cnt_wr),
		.result (result)
	);

	// stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage one payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= req.op;
			tid_s1 <= req.thread_id;
			keep_s1 <= req.keep_readers;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= result;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.status = out_q.status;
	assign rsp.wake_class = out_q.wake_class;
	assign rsp.reader_total_out = out_q.reader_total;
	assign rsp.nest_level_out = out_q.nest_level;

	// a held operation is never dropped while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1)
		else $error("stalled operation lost");

	// a pending result is not overwritten before its transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rsp.ready |-> !fire)
		else $error("result overwritten while stalled");

	// a stalled result stays valid and unchanged
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rsp.ready |=> out_valid_q && $stable(out_q))
		else $error("stalled result changed");

endmodule
